// ===== hdl/ard_pkg.sv =====
// ----------------------------------------------------------------------------
// ard_pkg
// shared types and constants for the adaptive range decoder
// ----------------------------------------------------------------------------
`default_nettype none
package ard_pkg;
    localparam int NUM_SYMBOLS_DEF = 257;
    localparam logic [31:0] RESCALE_LIMIT = 32'h0001_0000;
    localparam logic [31:0] TOP_MASK      = 32'hFF00_0000;
    localparam logic [31:0] LOW16_MASK    = 32'h0000_FFFF;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_FEED   = 2'd1,
        MODE_DECODE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NEED    = 2'd1,
        ST_BEYOND  = 2'd2,
        ST_EXHAUST = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_A    = 2'd1,
        PH_B    = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV1,
        S_DIV2,
        S_SRCH,
        S_SRCH_W,
        S_UPD,
        S_BUMP,
        S_RESC,
        S_OUT
    } fsm_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/ard_if.sv =====
// ----------------------------------------------------------------------------
// ard_in_if / ard_out_if
// valid/ready channels of the range decoder
// ----------------------------------------------------------------------------
`default_nettype none
interface ard_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [31:0] start_word;
    modport source (output valid, mode, data_byte, start_word, input ready);
    modport sink (input valid, mode, data_byte, start_word, output ready);
endinterface

interface ard_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] symbol;
    logic [1:0] status;
    logic       need_byte;
    logic       last;
    modport source (output valid, symbol, status, need_byte, last, input ready);
    modport sink (input valid, symbol, status, need_byte, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/ard_div.sv =====
// ----------------------------------------------------------------------------
// ard_div
// 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module ard_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ard_pkg::div_req_t req,
    output ard_pkg::div_rsp_t  rsp
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit into the partial remainder
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

// ===== hdl/adaptive_range_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// adaptive_range_decoder_unit
// order-0 adaptive range decoder, one request per transfer
// ----------------------------------------------------------------------------
// Each input transfer is one request (start, feed byte, decode) and yields
// exactly one output transfer. A start sweeps the count memories once; a
// feed byte or a refused decode goes straight to the output register.
// A decode runs two 32-bit divisions through one shared bit-serial divider,
// then a linear walk of the cumulative memory to find the symbol, then a
// sweep that increments the entries above the symbol. Walk and sweep
// together cover NUM_SYMBOLS+1 entries. When the total reaches 0x10000 a
// rescale sweep over every symbol follows. The final symbol of a stream
// skips the sweep, and a target beyond the total skips walk and sweep. The
// block accepts no request while one is in progress; a finished result is
// held in the output register until transferred. After reset the block
// sweeps the memories before it takes the first request.
`default_nettype none
module adaptive_range_decoder_unit #(
    parameter int NUM_SYMBOLS = ard_pkg::NUM_SYMBOLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    ard_in_if.sink           in_ch,
    ard_out_if.source        out_ch
);
    localparam int IW = $clog2(NUM_SYMBOLS + 1);

    // count memories; cum has NUM_SYMBOLS+1 entries, last one is the total
    logic [16:0] cum_mem  [NUM_SYMBOLS+1];
    logic [16:0] freq_mem [NUM_SYMBOLS];

    ard_pkg::fsm_t state_reg, state_next;
    ard_pkg::phase_t phase_reg, phase_next;

    logic [31:0] olen_reg;
    logic [31:0] low_reg, low_next;
    logic [31:0] range_reg, range_next;
    logic [31:0] code_reg, code_next;
    logic [31:0] emit_reg, emit_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] tgt_reg, tgt_next;
    logic [16:0] total_reg, total_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] sym_reg, sym_next;
    logic [16:0] cum_s_reg, cum_s_next;
    logic [16:0] acc_reg, acc_next;

    logic [8:0]  osym_reg, osym_next;
    logic [1:0]  ostat_reg, ostat_next;
    logic        olast_reg, olast_next;
    logic        ovalid_reg, ovalid_next;

    // registered memory reads
    logic [16:0] cum_rd_reg;
    logic [16:0] freq_rd_reg;
    logic [IW-1:0] rd_addr;

    // write port controls
    logic        cum_we, freq_we;
    logic [IW-1:0] cum_wa, freq_wa;
    logic [16:0] cum_wd, freq_wd;

    ard_pkg::div_req_t dreq;
    ard_pkg::div_rsp_t drsp;

    logic        in_xfer;
    logic        clr_fill_reg, clr_fill_next;
    logic        in_flag_reg;
    logic [16:0] halved;
    logic        a_cond;
    logic [31:0] low_sum;

    ard_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ard_pkg::S_IDLE) && !ovalid_reg;
    assign low_sum   = low_reg + range_reg;
    assign a_cond    = ((low_sum ^ low_reg) & ard_pkg::TOP_MASK) == 32'd0;
    assign halved    = (freq_rd_reg | 17'd2) >> 1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            olen_reg <= 32'd1;
        else if (cfg_we)
            olen_reg <= cfg_wdata;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ard_pkg::S_CLEAR:
                if (idx_reg == IW'(NUM_SYMBOLS))
                    state_next = ard_pkg::S_OUT;
            ard_pkg::S_IDLE:
                if (in_xfer)
                begin
                    if (ard_pkg::mode_t'(in_ch.mode) == ard_pkg::MODE_START)
                        state_next = ard_pkg::S_CLEAR;
                    else if (ard_pkg::mode_t'(in_ch.mode) == ard_pkg::MODE_DECODE
                             && emit_reg < olen_reg
                             && phase_reg == ard_pkg::PH_IDLE)
                        state_next = ard_pkg::S_DIV1;
                    else
                        state_next = ard_pkg::S_OUT;
                end
            ard_pkg::S_DIV1:
                if (drsp.done)
                    state_next = ard_pkg::S_DIV2;
            ard_pkg::S_DIV2:
                if (drsp.done)
                    state_next = (drsp.quotient >= {15'd0, total_reg}) ?
                                 ard_pkg::S_OUT : ard_pkg::S_SRCH;
            ard_pkg::S_SRCH:
                state_next = ard_pkg::S_SRCH_W;
            ard_pkg::S_SRCH_W:
                // cum_rd_reg holds cum[idx+1]
                if (idx_reg == IW'(NUM_SYMBOLS - 1)
                    || tgt_reg < {15'd0, cum_rd_reg})
                    state_next = ard_pkg::S_UPD;
                else
                    state_next = ard_pkg::S_SRCH;
            ard_pkg::S_UPD:
                state_next = (emit_reg >= olen_reg) ? ard_pkg::S_OUT : ard_pkg::S_BUMP;
            ard_pkg::S_BUMP:
                // leave after the write beat of the total entry
                if (idx_reg == IW'(NUM_SYMBOLS) && clr_fill_reg)
                    state_next = ard_pkg::S_RESC;
            ard_pkg::S_RESC:
                if (total_reg < 17'h10000 || idx_reg == IW'(NUM_SYMBOLS))
                    state_next = ard_pkg::S_OUT;
            ard_pkg::S_OUT:
                state_next = ard_pkg::S_IDLE;
            default:
                state_next = ard_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next   = phase_reg;
        low_next     = low_reg;
        range_next   = range_reg;
        code_next    = code_reg;
        emit_next    = emit_reg;
        r_next       = r_reg;
        tgt_next     = tgt_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        sym_next     = sym_reg;
        cum_s_next   = cum_s_reg;
        acc_next     = acc_reg;
        osym_next    = osym_reg;
        ostat_next   = ostat_reg;
        olast_next   = olast_reg;
        ovalid_next  = ovalid_reg;
        clr_fill_next = clr_fill_reg;
        cum_we  = 1'b0;
        freq_we = 1'b0;
        cum_wa  = idx_reg;
        freq_wa = idx_reg;
        cum_wd  = 17'(idx_reg);
        freq_wd = 17'd1;
        rd_addr = idx_reg;
        dreq.start    = 1'b0;
        dreq.dividend = range_reg;
        dreq.divisor  = {15'd0, total_reg};

        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ard_pkg::S_CLEAR:
            begin
                cum_we = 1'b1;
                freq_we = (idx_reg != IW'(NUM_SYMBOLS));
                idx_next = idx_reg + IW'(1);
                total_next = 17'(NUM_SYMBOLS);
            end
            ard_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    osym_next  = '0;
                    ostat_next = ard_pkg::ST_OK;
                    olast_next = 1'b0;
                    unique case (ard_pkg::mode_t'(in_ch.mode))
                        ard_pkg::MODE_START:
                        begin
                            code_next  = in_ch.start_word;
                            low_next   = '0;
                            range_next = ard_pkg::ALL_ONES;
                            phase_next = ard_pkg::PH_IDLE;
                            emit_next  = '0;
                            idx_next   = '0;
                        end
                        ard_pkg::MODE_FEED:
                            if (phase_reg == ard_pkg::PH_A)
                            begin
                                low_next   = low_reg << 8;
                                range_next = range_reg << 8;
                                code_next  = (code_reg << 8) + {24'd0, in_ch.data_byte};
                                clr_fill_next = 1'b1;
                            end
                            else if (phase_reg == ard_pkg::PH_B)
                            begin
                                range_next = (ard_pkg::RESCALE_LIMIT
                                             - (low_reg & ard_pkg::LOW16_MASK)) << 8;
                                low_next   = low_reg << 8;
                                code_next  = (code_reg << 8) + {24'd0, in_ch.data_byte};
                                phase_next = ((ard_pkg::RESCALE_LIMIT
                                              - (low_reg & ard_pkg::LOW16_MASK)) << 8)
                                             < ard_pkg::RESCALE_LIMIT ?
                                             ard_pkg::PH_B : ard_pkg::PH_IDLE;
                            end
                        ard_pkg::MODE_DECODE:
                            if (emit_reg >= olen_reg)
                                ostat_next = ard_pkg::ST_EXHAUST;
                            else if (phase_reg != ard_pkg::PH_IDLE)
                                ostat_next = ard_pkg::ST_NEED;
                            else
                                dreq.start = 1'b1;
                        default:
                        begin
                        end
                    endcase
                end
            end
            ard_pkg::S_DIV1:
                if (drsp.done)
                begin
                    r_next = (drsp.quotient == 32'd0) ? 32'd1 : drsp.quotient;
                    dreq.start    = 1'b1;
                    dreq.dividend = code_reg - low_reg;
                    dreq.divisor  = (drsp.quotient == 32'd0) ? 32'd1 : drsp.quotient;
                end
            ard_pkg::S_DIV2:
                if (drsp.done)
                begin
                    tgt_next = drsp.quotient;
                    idx_next = '0;
                    acc_next = '0;
                    if (drsp.quotient >= {15'd0, total_reg})
                        ostat_next = ard_pkg::ST_BEYOND;
                end
            ard_pkg::S_SRCH:
                rd_addr = idx_reg + IW'(1);
            ard_pkg::S_SRCH_W:
            begin
                // cum[idx] was the previous read, kept in acc
                if (idx_reg == IW'(NUM_SYMBOLS - 1) || tgt_reg < {15'd0, cum_rd_reg})
                begin
                    sym_next  = idx_reg;
                    cum_s_next = acc_reg;
                    emit_next = emit_reg + 32'd1;
                    rd_addr   = idx_reg;
                end
                else
                begin
                    acc_next = cum_rd_reg;
                    idx_next = idx_reg + IW'(1);
                end
            end
            ard_pkg::S_UPD:
            begin
                // freq_rd_reg holds freq[s]
                osym_next = 9'(sym_reg);
                if (emit_reg >= olen_reg)
                    olast_next = 1'b1;
                else
                begin
                    range_next = {15'd0, freq_rd_reg} * r_reg;
                    low_next   = low_reg + {15'd0, cum_s_reg} * r_reg;
                    freq_we    = 1'b1;
                    freq_wa    = sym_reg;
                    freq_wd    = freq_rd_reg + 17'd1;
                    idx_next   = sym_reg + IW'(1);
                    total_next = total_reg + 17'd1;
                end
            end
            ard_pkg::S_BUMP:
            begin
                // read-modify-write one entry: a read beat, then a write beat, alternating on the fill flag
                rd_addr = idx_reg;
                if (clr_fill_reg)
                begin
                    cum_we = 1'b1;
                    cum_wd = cum_rd_reg + 17'd1;
                    idx_next = idx_reg + IW'(1);
                    rd_addr = idx_reg + IW'(1);
                    clr_fill_next = 1'b0;
                    if (idx_reg == IW'(NUM_SYMBOLS))
                    begin
                        idx_next = '0;
                        acc_next = '0;
                        rd_addr  = idx_reg;
                    end
                end
                else
                    clr_fill_next = 1'b1;
            end
            ard_pkg::S_RESC:
            begin
                // on exit the flag tells the output beat to pick the next phase
                rd_addr = idx_reg;
                if (total_reg < 17'h10000)
                begin
                    clr_fill_next = 1'b1;
                end
                else if (idx_reg == IW'(NUM_SYMBOLS))
                begin
                    total_next = acc_reg;
                    clr_fill_next = 1'b1;
                end
                else if (clr_fill_reg)
                begin
                    freq_we = 1'b1;
                    freq_wd = halved;
                    cum_we  = 1'b1;
                    cum_wa  = idx_reg + IW'(1);
                    cum_wd  = acc_reg + halved;
                    acc_next = acc_reg + halved;
                    idx_next = idx_reg + IW'(1);
                    rd_addr  = idx_reg + IW'(1);
                    clr_fill_next = 1'b0;
                end
                else
                    clr_fill_next = 1'b1;
            end
            ard_pkg::S_OUT:
            begin
                ovalid_next = 1'b1;
                clr_fill_next = 1'b0;
                if (clr_fill_reg)
                    phase_next = a_cond ? ard_pkg::PH_A :
                                 (range_reg < ard_pkg::RESCALE_LIMIT) ?
                                 ard_pkg::PH_B : ard_pkg::PH_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ard_pkg::S_CLEAR;
            phase_reg  <= ard_pkg::PH_IDLE;
            low_reg    <= '0;
            range_reg  <= ard_pkg::ALL_ONES;
            code_reg   <= '0;
            emit_reg   <= '0;
            idx_reg    <= '0;
            total_reg  <= 17'(NUM_SYMBOLS);
            ovalid_reg <= 1'b0;
            clr_fill_reg <= 1'b0;
            ostat_reg  <= ard_pkg::ST_OK;
            olast_reg  <= 1'b0;
            osym_reg   <= '0;
        end
        else
        begin
            state_reg  <= (state_reg == ard_pkg::S_CLEAR && idx_reg == IW'(NUM_SYMBOLS)
                           && !in_flag_reg) ? ard_pkg::S_IDLE : state_next;
            phase_reg  <= phase_next;
            low_reg    <= low_next;
            range_reg  <= range_next;
            code_reg   <= code_next;
            emit_reg   <= emit_next;
            idx_reg    <= idx_next;
            total_reg  <= total_next;
            ovalid_reg <= ovalid_next;
            clr_fill_reg <= clr_fill_next;
            ostat_reg  <= ostat_next;
            olast_reg  <= olast_next;
            osym_reg   <= osym_next;
        end
    end

    // distinguishes the power-up sweep from a start request's sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_flag_reg <= 1'b0;
        else if (in_xfer)
            in_flag_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        tgt_reg   <= tgt_next;
        sym_reg   <= sym_next;
        cum_s_reg <= cum_s_next;
        acc_reg   <= acc_next;
    end

    // count memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cum_we)
            cum_mem[cum_wa] <= cum_wd;
        cum_rd_reg <= cum_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (freq_we)
            freq_mem[freq_wa] <= freq_wd;
        freq_rd_reg <= freq_mem[(rd_addr >= IW'(NUM_SYMBOLS)) ? IW'(0) : rd_addr];
    end

    assign out_ch.valid     = ovalid_reg;
    assign out_ch.symbol    = osym_reg;
    assign out_ch.status    = ostat_reg;
    assign out_ch.need_byte = (phase_reg != ard_pkg::PH_IDLE);
    assign out_ch.last      = olast_reg;
endmodule
`default_nettype wire

// ===== hdl/ard_checker.sv =====
// ----------------------------------------------------------------------------
// ard_checker
// port-level checks of the range decoder
// ----------------------------------------------------------------------------
`default_nettype none
module ard_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [1:0] out_status,
    input wire logic [8:0] out_symbol,
    input wire logic out_last
);
    // no new request while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("ready while result pending");
    // accepted request is followed by no immediate result
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("zero-latency result");
    // refused decodes carry no symbol
    a_sym: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status != ard_pkg::ST_OK) |-> (out_symbol == 9'd0 && !out_last))
        else $error("symbol on refused decode");
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_symbol)))
        else $error("result dropped");
endmodule

bind adaptive_range_decoder_unit ard_checker u_ard_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_symbol (out_ch.symbol),
    .out_last   (out_ch.last)
);
`default_nettype wire

// ===== dv/tb_adaptive_range_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_adaptive_range_decoder_unit
// self-checking bench: streams of start, feed and decode requests
// ----------------------------------------------------------------------------
// A planner walks its own copy of the decoder state to build well-formed
// streams (feed bytes while a pass is pending, else start or decode) with
// noise mixed in. The driver takes the planned requests from a queue. On
// each accepted transfer a second copy of the decoder state predicts the
// answer, and the monitor compares every output transfer with it.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_adaptive_range_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NS = ard_pkg::NUM_SYMBOLS_DEF;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int DRAIN_CYCLES = 700;

    // decoder state as the predictor keeps it
    typedef struct {
        logic [31:0] cum[0:NS];
        logic [31:0] freq[0:NS-1];
        logic [31:0] low;
        logic [31:0] rng;
        logic [31:0] code;
        logic [31:0] emitted;
        ard_pkg::phase_t phase;
    } dec_state_t;

    typedef struct {
        ard_pkg::mode_t mode;
        logic [7:0]  data_byte;
        logic [31:0] start_word;
    } request_t;

    typedef struct {
        logic [8:0] symbol;
        ard_pkg::status_t status;
        logic       need_byte;
        logic       last;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    ard_in_if  in_ch ();
    ard_out_if out_ch ();

    adaptive_range_decoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #2 clk = ~clk;

    request_t   pending_reqs[$];
    answer_t    expected_answers[$];
    dec_state_t plan_state;        // planner copy, runs ahead of the block
    dec_state_t track_state;       // checker copy, follows accepted transfers
    logic [31:0] plan_length;
    logic [31:0] track_length;
    int  err_count = 0;
    bit  quiet = 1'b0;             // no idling on either side
    int  in_gap = 0;
    int  out_stall = 0;
    int  idle_cycles = 0;

    function automatic void clear_model(inout dec_state_t st);
        for (int i = 0; i <= NS; i++) st.cum[i] = 32'(i);
        for (int i = 0; i < NS; i++) st.freq[i] = 32'd1;
    endfunction

    function automatic bit top_byte_settled(dec_state_t st);
        return (((st.low + st.rng) ^ st.low) & ard_pkg::TOP_MASK) == 32'd0;
    endfunction

    function automatic void shift_byte(inout dec_state_t st, input logic [7:0] b);
        st.low  = st.low << 8;
        st.rng  = st.rng << 8;
        st.code = (st.code << 8) + {24'd0, b};
    endfunction

    function automatic void phase_after_top(inout dec_state_t st);
        if (top_byte_settled(st)) st.phase = ard_pkg::PH_A;
        else if (st.rng < ard_pkg::RESCALE_LIMIT) st.phase = ard_pkg::PH_B;
        else st.phase = ard_pkg::PH_IDLE;
    endfunction

    // one request through the decoder, answer returned
    function automatic answer_t decode_request(inout dec_state_t st,
                                               input logic [31:0] len,
                                               input request_t rq);
        answer_t     ans;
        logic [31:0] total;
        logic [31:0] r;
        logic [31:0] target;
        int          s;
        ans.symbol = '0;
        ans.status = ard_pkg::ST_OK;
        ans.last   = 1'b0;
        case (rq.mode)
            ard_pkg::MODE_START:
            begin
                clear_model(st);
                st.code    = rq.start_word;
                st.low     = '0;
                st.rng     = ard_pkg::ALL_ONES;
                st.phase   = ard_pkg::PH_IDLE;
                st.emitted = '0;
            end
            ard_pkg::MODE_FEED:
            begin
                if (st.phase == ard_pkg::PH_A)
                begin
                    shift_byte(st, rq.data_byte);
                    phase_after_top(st);
                end
                else if (st.phase == ard_pkg::PH_B)
                begin
                    st.rng = ard_pkg::RESCALE_LIMIT - (st.low & ard_pkg::LOW16_MASK);
                    shift_byte(st, rq.data_byte);
                    st.phase = (st.rng < ard_pkg::RESCALE_LIMIT) ?
                               ard_pkg::PH_B : ard_pkg::PH_IDLE;
                end
            end
            ard_pkg::MODE_DECODE:
            begin
                if (st.emitted >= len)
                    ans.status = ard_pkg::ST_EXHAUST;
                else if (st.phase != ard_pkg::PH_IDLE)
                    ans.status = ard_pkg::ST_NEED;
                else
                begin
                    total = st.cum[NS];
                    r = (total != 32'd0) ? st.rng / total : st.rng;
                    if (r == 32'd0) r = 32'd1;
                    target = (st.code - st.low) / r;
                    if (target >= total)
                        ans.status = ard_pkg::ST_BEYOND;
                    else
                    begin
                        s = 0;
                        while (s < NS - 1 && target >= st.cum[s+1]) s++;
                        ans.symbol = s[8:0];
                        st.emitted = st.emitted + 32'd1;
                        if (st.emitted >= len)
                            ans.last = 1'b1;
                        else
                        begin
                            st.rng = st.freq[s] * r;
                            st.low = st.low + st.cum[s] * r;
                            // bump the counts above the symbol
                            st.freq[s] = st.freq[s] + 32'd1;
                            for (int i = s + 1; i <= NS; i++) st.cum[i] = st.cum[i] + 32'd1;
                            if (st.cum[NS] >= ard_pkg::RESCALE_LIMIT)
                            begin
                                st.cum[0] = '0;
                                for (int i = 0; i < NS; i++)
                                begin
                                    st.freq[i] = (st.freq[i] | 32'd2) >> 1;
                                    st.cum[i+1] = st.cum[i] + st.freq[i];
                                end
                            end
                            phase_after_top(st);
                        end
                    end
                end
            end
            default: ;
        endcase
        ans.need_byte = (st.phase != ard_pkg::PH_IDLE);
        return ans;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got %0d, want %0d at %0t", field, got, want, $realtime);
        err_count++;
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        request_t rq;
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.mode       <= ard_pkg::MODE_START;
            in_ch.data_byte  <= '0;
            in_ch.start_word <= '0;
        end
        else
        begin
            // accepted transfer: predict the answer it will bring
            if (in_ch.valid && in_ch.ready)
            begin
                rq.mode       = ard_pkg::mode_t'(in_ch.mode);
                rq.data_byte  = in_ch.data_byte;
                rq.start_word = in_ch.start_word;
                expected_answers.push_back(decode_request(track_state, track_length, rq));
                idle_cycles = 0;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    rq = pending_reqs.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.mode       <= rq.mode;
                    in_ch.data_byte  <= rq.data_byte;
                    in_ch.start_word <= rq.start_word;
                    // idle burst before the next request
                    if (!quiet && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 6);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                idle_cycles = 0;
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected transfer", 1, 0);
                else
                begin
                    want = expected_answers.pop_front();
                    if (out_ch.symbol !== want.symbol)
                        report_mismatch("symbol", out_ch.symbol, want.symbol);
                    if (out_ch.status !== want.status)
                        report_mismatch("status", out_ch.status, want.status);
                    if (out_ch.need_byte !== want.need_byte)
                        report_mismatch("need_byte", out_ch.need_byte, want.need_byte);
                    if (out_ch.last !== want.last)
                        report_mismatch("last", out_ch.last, want.last);
                end
            end
            // receiver stalls in bursts
            if (out_stall > 0)
            begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall = $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_adaptive_range_decoder_unit: done, errors");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic plan(input ard_pkg::mode_t m, input logic [7:0] b, input logic [31:0] w);
        request_t rq;
        rq.mode       = m;
        rq.data_byte  = b;
        rq.start_word = w;
        void'(decode_request(plan_state, plan_length, rq));
        pending_reqs.push_back(rq);
    endtask

    // feed bytes until no pass is pending, at most eight
    task automatic feed_pending(input logic [7:0] b);
        for (int i = 0; i < 8 && plan_state.phase != ard_pkg::PH_IDLE; i++)
            plan(ard_pkg::MODE_FEED, b, '0);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_ch.valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // register written only with the block idle
    task automatic write_length(input logic [31:0] len);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        track_length = len;
        plan_length  = len;
    endtask

    task automatic random_stream(input int n_items);
        int pick;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                plan(ard_pkg::MODE_START, 8'($urandom),
                     ($urandom_range(0, 9) == 0) ? '0 : $urandom);
            else if (pick < 6)
                plan(ard_pkg::MODE_NONE, 8'($urandom), $urandom);
            else if (pick < 10)
                plan(($urandom_range(0, 1) != 0) ? ard_pkg::MODE_FEED : ard_pkg::MODE_DECODE,
                     8'($urandom), $urandom);
            else if (plan_state.phase != ard_pkg::PH_IDLE)
                plan(ard_pkg::MODE_FEED, 8'($urandom), $urandom);
            else if (plan_state.emitted >= plan_length && pick < 80)
                plan(ard_pkg::MODE_START, 8'($urandom), $urandom);
            else
                plan(ard_pkg::MODE_DECODE, 8'($urandom), $urandom);
        end
    endtask

    initial
    begin
        clear_model(plan_state);
        plan_state.low = '0;
        plan_state.rng = ard_pkg::ALL_ONES;
        plan_state.code = '0;
        plan_state.emitted = '0;
        plan_state.phase = ard_pkg::PH_IDLE;
        track_state  = plan_state;
        plan_length  = 32'd1;
        track_length = 32'd1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: decode at reset length, refused decode, feeds, ignored byte
        plan(ard_pkg::MODE_DECODE, 8'h00, '0);
        plan(ard_pkg::MODE_DECODE, 8'h00, '0);
        plan(ard_pkg::MODE_FEED, 8'hFF, '0);
        plan(ard_pkg::MODE_NONE, 8'hFF, ard_pkg::ALL_ONES);
        write_length(32'd3);
        plan(ard_pkg::MODE_START, 8'h00, 32'h0000_0000);
        plan(ard_pkg::MODE_DECODE, 8'h00, '0);
        plan(ard_pkg::MODE_DECODE, 8'h00, '0);
        feed_pending(8'hFF);
        plan(ard_pkg::MODE_FEED, 8'hA5, '0);
        plan(ard_pkg::MODE_DECODE, 8'h00, '0);
        feed_pending(8'h00);
        plan(ard_pkg::MODE_DECODE, 8'h00, '0);
        plan(ard_pkg::MODE_DECODE, 8'h00, '0);
        plan(ard_pkg::MODE_START, 8'h00, ard_pkg::ALL_ONES);
        plan(ard_pkg::MODE_DECODE, 8'h00, '0);
        plan(ard_pkg::MODE_START, 8'h00, 32'h8000_0000);
        plan(ard_pkg::MODE_DECODE, 8'h00, '0);
        plan(ard_pkg::MODE_NONE, 8'h00, '0);

        write_length(32'd0);
        plan(ard_pkg::MODE_START, 8'h00, 32'h1234_5678);
        random_stream(60);
        write_length(32'd1);
        random_stream(200);
        write_length(32'd5);
        random_stream(300);
        write_length(32'd40);
        random_stream(400);
        write_length($urandom_range(2, 200));
        random_stream(300);
        write_length(ard_pkg::ALL_ONES);
        random_stream(250);
        // last stretch without idling
        wait_drained();
        quiet = 1'b1;
        random_stream(220);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && expected_answers.size() == 0)
            $display("tb_adaptive_range_decoder_unit: done, clean");
        else
            $display("tb_adaptive_range_decoder_unit: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
